### rtl/ipv4cidr_pkg.sv
// Package with the types and constants shared by the IPv4 CIDR text parser modules.
package ipv4cidr_pkg;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned OCTET_W  = 8;
	localparam int unsigned PLEN_W   = 6;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OUT_W    = 40;

	localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2e;
	localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2f;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

	localparam logic [11:0]       OCTET_MAX  = 12'd255;
	localparam logic [8:0]        PREFIX_MAX = 9'd32;
	localparam logic [PLEN_W-1:0] PLEN_FULL  = 6'd32;
	localparam logic [ADDR_W-1:0] FULL_MASK  = 32'hffff_ffff;

	// Parse phase, one-hot.
	typedef enum logic [5:0] {
		PH_OCT0   = 6'b000001,
		PH_OCT1   = 6'b000010,
		PH_OCT2   = 6'b000100,
		PH_OCT3   = 6'b001000,
		PH_PREFIX = 6'b010000,
		PH_ERROR  = 6'b100000
	} phase_t;

	// Parser state carried from one character to the next.
	typedef struct packed {
		phase_t              phase;
		logic [OCTET_W-1:0]  dec_acc;
		logic [ADDR_W-1:0]   addr;
		logic [PLEN_W-1:0]   pfx_acc;
		logic                digit_seen;
	} parse_state_t;

	// One parse result.
	typedef struct packed {
		logic                parse_ok;
		logic [PLEN_W-1:0]   prefix_length;
		logic [ADDR_W-1:0]   network_address;
	} parse_result_t;

	localparam parse_state_t STATE_RESET = '{
		phase:      PH_OCT0,
		dec_acc:    '0,
		addr:       '0,
		pfx_acc:    '0,
		digit_seen: 1'b0
	};

endpackage

### rtl/ipv4cidr_step.sv
// Next-state and result logic of the parser for one character.
module ipv4cidr_step
	import ipv4cidr_pkg::*;
(
	input  parse_state_t        cur,
	input  logic [BYTE_W-1:0]   text_byte,
	output parse_state_t        nxt,
	output logic                emit,
	output parse_result_t       res
);

	logic                is_digit;
	logic [3:0]          digit;
	logic [11:0]         dec_v;
	logic [8:0]          pfx_v;
	logic [ADDR_W-1:0]   addr_join;
	logic [PLEN_W-1:0]   mask_shift;

	// Decimal digit decode and times-ten accumulation by shifts.
	assign is_digit   = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
	assign digit      = is_digit ? 4'(text_byte - CHAR_ZERO) : 4'd0;
	assign dec_v      = ({4'd0, cur.dec_acc} << 3) + ({4'd0, cur.dec_acc} << 1)
		+ {8'd0, digit};
	assign pfx_v      = ({3'd0, cur.pfx_acc} << 3) + ({3'd0, cur.pfx_acc} << 1)
		+ {5'd0, digit};
	assign addr_join  = {cur.addr[ADDR_W-OCTET_W-1:0], cur.dec_acc};
	assign mask_shift = PLEN_FULL - cur.pfx_acc;

	// Phase update for the current character.
	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '0;
		unique case (cur.phase) inside
			PH_OCT0, PH_OCT1, PH_OCT2, PH_OCT3: begin
				if (is_digit) begin
					if (dec_v > OCTET_MAX) begin
						nxt.phase = PH_ERROR;
					end else begin
						nxt.dec_acc    = dec_v[OCTET_W-1:0];
						nxt.digit_seen = 1'b1;
					end
				end else if (text_byte == CHAR_DOT && cur.phase != PH_OCT3
					&& cur.digit_seen) begin
					nxt.addr       = addr_join;
					nxt.dec_acc    = '0;
					nxt.digit_seen = 1'b0;
					nxt.phase      = phase_t'({cur.phase[4:0], 1'b0});
				end else if (text_byte == CHAR_SLASH && cur.phase == PH_OCT3
					&& cur.digit_seen) begin
					nxt.addr       = addr_join;
					nxt.dec_acc    = '0;
					nxt.pfx_acc    = '0;
					nxt.digit_seen = 1'b0;
					nxt.phase      = PH_PREFIX;
				end else if (text_byte == CHAR_NUL) begin
					emit = 1'b1;
					nxt  = STATE_RESET;
					if (cur.phase == PH_OCT3 && cur.digit_seen) begin
						res.network_address = addr_join;
						res.prefix_length   = PLEN_FULL;
						res.parse_ok        = 1'b1;
					end
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			PH_PREFIX: begin
				if (is_digit) begin
					if (pfx_v > PREFIX_MAX) begin
						nxt.phase = PH_ERROR;
					end else begin
						nxt.pfx_acc    = pfx_v[PLEN_W-1:0];
						nxt.digit_seen = 1'b1;
					end
				end else if (text_byte == CHAR_NUL) begin
					emit = 1'b1;
					nxt  = STATE_RESET;
					if (cur.digit_seen && cur.pfx_acc != '0) begin
						res.network_address = cur.addr & (FULL_MASK << mask_shift);
						res.prefix_length   = cur.pfx_acc;
						res.parse_ok        = 1'b1;
					end
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			default: begin
				// Error phase and unused codes wait for the terminator.
				if (text_byte == CHAR_NUL) begin
					emit = 1'b1;
					nxt  = STATE_RESET;
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
		endcase
	end

endmodule

### rtl/ipv4cidr_pkg_unused_guard.sv
// Output stage that holds one parse result until the receiver takes it.
module ipv4cidr_out_reg
	import ipv4cidr_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  parse_result_t  load_res,
	input  logic           ready,
	output logic           valid,
	output logic           free,
	output parse_result_t  res
);

	logic          valid_q;
	parse_result_t res_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign res   = res_q;

	// Valid flag: set on a load, cleared once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

endmodule

### rtl/ipv4_cidr_text_parser_core.sv
// Top level of the IPv4 CIDR text parser.
//
// The block reads the text of a dotted-decimal IPv4 address, one ASCII
// character per request on the s_ channel, optionally followed by a
// "/prefix" suffix and always ended by a zero byte. Every character but the
// zero byte only updates the parser state. The zero byte yields one result
// request on the m_ channel: the address ANDed with the prefix mask, the
// prefix length (32 when none is given) and a parse_ok flag; a malformed
// string gives a result with all fields zero. The parser then starts over.
//
// Throughput is one character per cycle unless a terminator waits for a full
// output register. A character is captured in an input register, the
// next-state logic works on it there, and a terminator's result is loaded
// into the output register, which offers it on the m_ channel. The output
// register decouples the sides: a stalled receiver holds back only a
// terminator waiting in the input register, while other characters flow.
// Reset clears the parser state and both channel valid flags.
module ipv4_cidr_text_parser_core
	import ipv4cidr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] text_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // [31:0] network_address, [37:32] prefix_length,
	                                    // [38] parse_ok, [39] zero
);

	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s1;
	parse_state_t      state_q;
	parse_state_t      state_nxt;
	logic              emit;
	parse_result_t     step_res;
	parse_result_t     out_res;
	logic              out_free;
	logic              advance;
	logic              load;

	ipv4cidr_step u_step (
		.cur       (state_q),
		.text_byte (byte_s1),
		.nxt       (state_nxt),
		.emit      (emit),
		.res       (step_res)
	);

	// A staged character moves on unless it is a terminator facing a full output.
	assign advance  = valid_s1 && (!emit || out_free);
	assign load     = advance && emit;
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	ipv4cidr_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.load_res (step_res),
		.ready    (m_tready),
		.valid    (m_tvalid),
		.free     (out_free),
		.res      (out_res)
	);

	assign m_tdata = {1'b0, out_res.parse_ok, out_res.prefix_length,
		out_res.network_address};

	// A failed parse reports all fields as zero.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !out_res.parse_ok) |->
		(out_res.network_address == '0 && out_res.prefix_length == '0))
		else $error("invalid result carries nonzero fields");

	// A good parse has a prefix length between 1 and 32.
	a_ok_plen: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_res.parse_ok) |->
		(out_res.prefix_length != '0 && out_res.prefix_length <= PLEN_FULL))
		else $error("prefix length out of range on a good result");

	// The parser restarts after every terminator.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (state_q.phase == PH_OCT0 && !state_q.digit_seen
		&& state_q.addr == '0))
		else $error("parser state not cleared after terminator");

	// The input side stalls only behind a terminator and a blocked output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && emit && m_tvalid && !m_tready))
		else $error("input stalled without a blocked result");

endmodule
